FILE: sv/scc_pkg.sv
// scc_pkg: types and codes of the command checker.
// Request and result payload structs, state struct, opcodes, sense and action codes.
// No dependencies.
package scc_pkg;

  localparam logic [1:0] MODE_COMMAND = 2'd0;
  localparam logic [1:0] MODE_DONE    = 2'd1;
  localparam logic [1:0] MODE_CARD    = 2'd2;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
  localparam logic [7:0] OP_FORMAT_UNIT     = 8'h04;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_WRITE6          = 8'h0A;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_RESERVE         = 8'h16;
  localparam logic [7:0] OP_RELEASE         = 8'h17;
  localparam logic [7:0] OP_SEND_DIAG       = 8'h1D;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2A;
  localparam logic [7:0] OP_VERIFY          = 8'h2F;

  localparam logic [2:0] ACT_STATUS   = 3'd0;
  localparam logic [2:0] ACT_READ     = 3'd1;
  localparam logic [2:0] ACT_WRITE    = 3'd2;
  localparam logic [2:0] ACT_VERIFY   = 3'd3;
  localparam logic [2:0] ACT_CAPACITY = 3'd4;
  localparam logic [2:0] ACT_SENSE    = 3'd5;
  localparam logic [2:0] ACT_INQUIRY  = 3'd6;

  localparam logic [1:0] XFER_NONE   = 2'd0;
  localparam logic [1:0] XFER_READ   = 2'd1;
  localparam logic [1:0] XFER_WRITE  = 2'd2;
  localparam logic [1:0] XFER_VERIFY = 2'd3;

  localparam logic [2:0] SK_NONE       = 3'd0;
  localparam logic [2:0] SK_NOT_READY  = 3'd1;
  localparam logic [2:0] SK_MEDIUM     = 3'd2;
  localparam logic [2:0] SK_ILLEGAL    = 3'd3;
  localparam logic [2:0] SK_ATTENTION  = 3'd4;
  localparam logic [2:0] SK_MISCOMPARE = 3'd5;

  localparam logic [2:0] AC_NONE         = 3'd0;
  localparam logic [2:0] AC_LBA_RANGE    = 3'd1;
  localparam logic [2:0] AC_BAD_OPCODE   = 3'd2;
  localparam logic [2:0] AC_NO_MEDIUM    = 3'd3;
  localparam logic [2:0] AC_BAD_LUN      = 3'd4;
  localparam logic [2:0] AC_BECAME_READY = 3'd5;
  localparam logic [2:0] AC_BAD_FIELD    = 3'd6;

  localparam logic [15:0] SIX_BYTE_ZERO_COUNT = 16'd256;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  opcode;
    logic        is_icd;
    logic [31:0] cdb_front;
    logic [39:0] cdb_back;
    logic        transfer_failed;
    logic        pio_failed;
    logic        card_ready;
    logic        media_changed;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        check_condition;
    logic [2:0]  sense_code;
    logic [2:0]  additional_code;
    logic [31:0] start_sector;
    logic [15:0] sectors;
    logic [7:0]  data_length;
    logic [2:0]  unit_number;
    logic [31:0] last_sector;
    logic [15:0] read_fail_count;
    logic [15:0] write_fail_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  stored_sense;
    logic [2:0]  stored_additional;
    logic        attention_pending;
    logic        medium_ready;
    logic [1:0]  pending_transfer;
    logic [15:0] read_failures;
    logic [15:0] write_failures;
  } state_t;

endpackage

FILE: sv/scc_decode.sv
// scc_decode: single-pass decision logic for one request.
// Runs the lun, ready, attention and range checks and gives the result and next state.
// Depends on scc_pkg.
module scc_decode (
  input  scc_pkg::req_t   req,
  input  scc_pkg::state_t st,
  input  logic [31:0]     capacity,
  output scc_pkg::state_t st_next,
  output scc_pkg::rsp_t   rsp,
  output logic            has_rsp
);

  logic [7:0]  b1, b2, b3, b4, b5, b6, b8, b9;
  logic [2:0]  lun;
  logic        rs_or_inq, six, ten, needs_medium;
  logic [31:0] start;
  logic [15:0] count;
  logic [32:0] end_sum;
  logic        inq_evpd;
  logic [7:0]  inq_len;

  assign b1 = req.cdb_front[31:24];
  assign b2 = req.cdb_front[23:16];
  assign b3 = req.cdb_front[15:8];
  assign b4 = req.cdb_front[7:0];
  assign b5 = req.cdb_back[39:32];
  assign b6 = req.cdb_back[31:24];
  assign b8 = req.cdb_back[15:8];
  assign b9 = req.cdb_back[7:0];

  assign lun       = req.is_icd ? b2[7:5] : b1[7:5];
  assign inq_evpd  = req.is_icd ? b2[0] : b1[0];
  assign inq_len   = req.is_icd ? b5 : b4;
  assign rs_or_inq = (req.opcode == scc_pkg::OP_REQUEST_SENSE) ||
                     (req.opcode == scc_pkg::OP_INQUIRY);
  assign six = (req.opcode == scc_pkg::OP_READ6) || (req.opcode == scc_pkg::OP_WRITE6);
  assign ten = (req.opcode == scc_pkg::OP_READ10) || (req.opcode == scc_pkg::OP_WRITE10) ||
               (req.opcode == scc_pkg::OP_VERIFY);
  assign needs_medium = six || (req.opcode == scc_pkg::OP_READ10) ||
                        (req.opcode == scc_pkg::OP_WRITE10) ||
                        (req.opcode == scc_pkg::OP_FORMAT_UNIT) ||
                        (req.opcode == scc_pkg::OP_READ_CAPACITY);

  always_comb begin
    if (six) begin
      start = {11'd0, b1[4:0], b2, b3};
      count = (b4 == 8'd0) ? scc_pkg::SIX_BYTE_ZERO_COUNT : {8'd0, b4};
    end else begin
      start = {b3, b4, b5, b6};
      count = {b8, b9};
    end
  end

  assign end_sum = {1'b0, start} + {17'd0, count};

  always_comb begin
    st_next = st;
    rsp     = '0;
    has_rsp = 1'b0;
    case (req.mode)
      scc_pkg::MODE_CARD: begin
        st_next.medium_ready = req.card_ready;
        if (req.media_changed) begin
          st_next.attention_pending = 1'b1;
        end
      end
      scc_pkg::MODE_DONE: begin
        if (st.pending_transfer != scc_pkg::XFER_NONE) begin
          has_rsp = 1'b1;
          st_next.pending_transfer = scc_pkg::XFER_NONE;
          st_next.stored_sense = scc_pkg::SK_NONE;
          st_next.stored_additional = scc_pkg::AC_NONE;
          if (st.pending_transfer == scc_pkg::XFER_VERIFY) begin
            if (req.transfer_failed) begin
              st_next.stored_sense = scc_pkg::SK_MISCOMPARE;
              rsp.check_condition = 1'b1;
              rsp.sense_code = scc_pkg::SK_MISCOMPARE;
            end
          end else begin
            if (req.transfer_failed || req.pio_failed) begin
              if (st.pending_transfer == scc_pkg::XFER_READ) begin
                st_next.read_failures = st.read_failures + 16'd1;
              end else begin
                st_next.write_failures = st.write_failures + 16'd1;
              end
            end
            if (req.transfer_failed) begin
              st_next.stored_sense = scc_pkg::SK_MEDIUM;
              rsp.check_condition = 1'b1;
              rsp.sense_code = scc_pkg::SK_MEDIUM;
            end
          end
        end
      end
      scc_pkg::MODE_COMMAND: begin
        has_rsp = 1'b1;
        st_next.pending_transfer = scc_pkg::XFER_NONE;
        rsp.unit_number = lun;
        if (lun != 3'd0 && !rs_or_inq) begin
          rsp.check_condition = 1'b1;
          rsp.sense_code = scc_pkg::SK_ILLEGAL;
          rsp.additional_code = scc_pkg::AC_BAD_LUN;
        end else if (!st.medium_ready && needs_medium) begin
          rsp.check_condition = 1'b1;
          rsp.sense_code = scc_pkg::SK_NOT_READY;
          rsp.additional_code = scc_pkg::AC_NO_MEDIUM;
        end else if (st.attention_pending && !rs_or_inq) begin
          st_next.attention_pending = 1'b0;
          rsp.check_condition = 1'b1;
          rsp.sense_code = scc_pkg::SK_ATTENTION;
          rsp.additional_code = scc_pkg::AC_BECAME_READY;
        end else if (six || ten) begin
          if (count != 16'd0 && end_sum > {1'b0, capacity}) begin
            rsp.check_condition = 1'b1;
            rsp.sense_code = scc_pkg::SK_ILLEGAL;
            rsp.additional_code = scc_pkg::AC_LBA_RANGE;
          end else begin
            if (req.opcode == scc_pkg::OP_READ6 || req.opcode == scc_pkg::OP_READ10) begin
              rsp.action = scc_pkg::ACT_READ;
              st_next.pending_transfer = scc_pkg::XFER_READ;
            end else if (req.opcode == scc_pkg::OP_VERIFY) begin
              rsp.action = scc_pkg::ACT_VERIFY;
              st_next.pending_transfer = scc_pkg::XFER_VERIFY;
            end else begin
              rsp.action = scc_pkg::ACT_WRITE;
              st_next.pending_transfer = scc_pkg::XFER_WRITE;
            end
            rsp.start_sector = start;
            rsp.sectors = count;
          end
        end else begin
          unique case (req.opcode)
            scc_pkg::OP_TEST_UNIT_READY, scc_pkg::OP_SEND_DIAG,
            scc_pkg::OP_RESERVE, scc_pkg::OP_RELEASE: begin
              if (!st.medium_ready) begin
                rsp.check_condition = 1'b1;
                rsp.sense_code = scc_pkg::SK_NOT_READY;
                rsp.additional_code = scc_pkg::AC_NO_MEDIUM;
              end
            end
            scc_pkg::OP_FORMAT_UNIT: begin
            end
            scc_pkg::OP_READ_CAPACITY: begin
              rsp.action = scc_pkg::ACT_CAPACITY;
              rsp.last_sector = capacity - 32'd1;
            end
            scc_pkg::OP_REQUEST_SENSE: begin
              st_next.attention_pending = 1'b0;
              rsp.action = scc_pkg::ACT_SENSE;
              rsp.data_length = b4;
              if (lun != 3'd0) begin
                rsp.sense_code = scc_pkg::SK_ILLEGAL;
                rsp.additional_code = scc_pkg::AC_BAD_LUN;
              end else if (st.attention_pending) begin
                rsp.sense_code = scc_pkg::SK_NONE;
                rsp.additional_code = scc_pkg::AC_NONE;
              end else begin
                rsp.sense_code = st.stored_sense;
                rsp.additional_code = st.stored_additional;
              end
            end
            scc_pkg::OP_INQUIRY: begin
              st_next.attention_pending = 1'b0;
              if (inq_evpd) begin
                rsp.check_condition = 1'b1;
                rsp.sense_code = scc_pkg::SK_ILLEGAL;
                rsp.additional_code = scc_pkg::AC_BAD_FIELD;
              end else begin
                rsp.action = scc_pkg::ACT_INQUIRY;
                rsp.data_length = inq_len;
              end
            end
            default: begin
              rsp.check_condition = 1'b1;
              rsp.sense_code = scc_pkg::SK_ILLEGAL;
              rsp.additional_code = scc_pkg::AC_BAD_OPCODE;
            end
          endcase
        end
        // transfer starts leave the stored sense alone, request sense clears it, everything else stores its result
        if (rsp.action != scc_pkg::ACT_READ && rsp.action != scc_pkg::ACT_WRITE &&
            rsp.action != scc_pkg::ACT_VERIFY) begin
          if (rsp.action == scc_pkg::ACT_SENSE) begin
            st_next.stored_sense = scc_pkg::SK_NONE;
            st_next.stored_additional = scc_pkg::AC_NONE;
          end else begin
            st_next.stored_sense = rsp.sense_code;
            st_next.stored_additional = rsp.additional_code;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.read_fail_count  = st_next.read_failures;
    rsp.write_fail_count = st_next.write_failures;
  end

endmodule

FILE: sv/scsi_command_check_and_sense.sv
// scsi_command_check_and_sense: top level of the scsi target command checker.
// Request register, target state, capacity register and result register around scc_decode.
// Depends on scc_pkg and scc_decode.
//
//  channel  signals                          payload
//  in       in_valid / in_ready              in_data   (scc_pkg::req_t)
//  out      out_valid / out_ready            out_data  (scc_pkg::rsp_t)
//  cfg      cfg_valid / cfg_ready            cfg_data  (capacity in sectors)
//
// a request is registered, decided combinationally and its result registered,
// one request per cycle sustained while out_ready does not stall the result register
// the decision stage moves whenever the result register is empty or being taken
// requests that give no result still pass through the decision stage and update state
// rst clears state, capacity and both valid flags; cfg_ready is always high
module scsi_command_check_and_sense (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scc_pkg::req_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scc_pkg::rsp_t       out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic            req_valid;
  scc_pkg::req_t   req;
  scc_pkg::state_t st;
  scc_pkg::state_t st_next;
  logic [31:0]     capacity;
  scc_pkg::rsp_t   rsp;
  logic            has_rsp;
  logic            advance;

  scc_decode u_decode (
    .req      (req),
    .st       (st),
    .capacity (capacity),
    .st_next  (st_next),
    .rsp      (rsp),
    .has_rsp  (has_rsp)
  );

  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_rsp;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_rsp) begin
      out_data <= rsp;
    end
  end

endmodule

FILE: sim/testbench.sv
// testbench for scsi_command_check_and_sense: directed and random requests, with a
// per-request predictor of the target state and a scoreboard of expected statuses.
// Depends on scc_pkg and the block under test.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [7:0] OP_UNDEFINED = 8'hFF;
  localparam int PHASE_REQUESTS = 190;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  scc_pkg::req_t   in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  scc_pkg::rsp_t   out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [31:0]     cfg_data = '0;

  scc_pkg::req_t   cmd_queue[$];
  scc_pkg::rsp_t   status_due[$];
  scc_pkg::state_t target = '0;
  logic [31:0]     capacity = '0;
  int              mismatches = 0;
  int              results_seen = 0;
  bit              req_fire = 1'b0;
  bit              calm = 1'b0;
  int              idle_left = 0;
  int              stall_left = 0;
  int              hold_left = 0;
  int              holds_done = 0;

  scsi_command_check_and_sense DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic refuse(inout scc_pkg::rsp_t res, input logic [2:0] sk,
                        input logic [2:0] ac);
    res.check_condition = 1'b1;
    res.sense_code = sk;
    res.additional_code = ac;
    target.stored_sense = sk;
    target.stored_additional = ac;
  endtask

  task automatic clear_sense();
    target.stored_sense = scc_pkg::SK_NONE;
    target.stored_additional = scc_pkg::AC_NONE;
  endtask

  // target state update and status for one request
  task automatic judge_request(input scc_pkg::req_t r, output bit emits,
                               output scc_pkg::rsp_t res);
    logic [1:9][7:0] b;
    logic [2:0]      lun;
    logic [1:0]      kind;
    logic [31:0]     start;
    logic [15:0]     count;
    bit              rs_inq;
    bit              six;
    bit              ten;
    emits = 1'b0;
    res = '0;
    b = {r.cdb_front, r.cdb_back};
    lun = r.is_icd ? b[2][7:5] : b[1][7:5];
    rs_inq = r.opcode inside {scc_pkg::OP_REQUEST_SENSE, scc_pkg::OP_INQUIRY};
    six = r.opcode inside {scc_pkg::OP_READ6, scc_pkg::OP_WRITE6};
    ten = r.opcode inside {scc_pkg::OP_READ10, scc_pkg::OP_WRITE10, scc_pkg::OP_VERIFY};
    case (r.mode)
      scc_pkg::MODE_CARD: begin
        target.medium_ready = r.card_ready;
        if (r.media_changed) target.attention_pending = 1'b1;
      end
      scc_pkg::MODE_DONE: begin
        if (target.pending_transfer != scc_pkg::XFER_NONE) begin
          kind = target.pending_transfer;
          target.pending_transfer = scc_pkg::XFER_NONE;
          emits = 1'b1;
          if (kind != scc_pkg::XFER_VERIFY && (r.transfer_failed || r.pio_failed)) begin
            if (kind == scc_pkg::XFER_READ) target.read_failures += 16'd1;
            else target.write_failures += 16'd1;
          end
          if (!r.transfer_failed) clear_sense();
          else refuse(res, (kind == scc_pkg::XFER_VERIFY) ? scc_pkg::SK_MISCOMPARE :
                      scc_pkg::SK_MEDIUM, scc_pkg::AC_NONE);
        end
      end
      scc_pkg::MODE_COMMAND: begin
        emits = 1'b1;
        res.unit_number = lun;
        target.pending_transfer = scc_pkg::XFER_NONE;
        if (lun != 3'd0 && !rs_inq) begin
          refuse(res, scc_pkg::SK_ILLEGAL, scc_pkg::AC_BAD_LUN);
        end else if (!target.medium_ready && (six ||
                     r.opcode inside {scc_pkg::OP_READ10, scc_pkg::OP_WRITE10,
                                      scc_pkg::OP_FORMAT_UNIT,
                                      scc_pkg::OP_READ_CAPACITY})) begin
          refuse(res, scc_pkg::SK_NOT_READY, scc_pkg::AC_NO_MEDIUM);
        end else if (target.attention_pending && !rs_inq) begin
          target.attention_pending = 1'b0;
          refuse(res, scc_pkg::SK_ATTENTION, scc_pkg::AC_BECAME_READY);
        end else if (six || ten) begin
          if (six) begin
            start = {11'd0, b[1][4:0], b[2], b[3]};
            count = (b[4] == 8'd0) ? scc_pkg::SIX_BYTE_ZERO_COUNT : {8'd0, b[4]};
          end else begin
            start = b[3:6];
            count = b[8:9];
          end
          if (count != 16'd0 && ({1'b0, start} + {17'd0, count}) > {1'b0, capacity}) begin
            refuse(res, scc_pkg::SK_ILLEGAL, scc_pkg::AC_LBA_RANGE);
          end else begin
            case (r.opcode)
              scc_pkg::OP_READ6, scc_pkg::OP_READ10: begin
                res.action = scc_pkg::ACT_READ;
                target.pending_transfer = scc_pkg::XFER_READ;
              end
              scc_pkg::OP_VERIFY: begin
                res.action = scc_pkg::ACT_VERIFY;
                target.pending_transfer = scc_pkg::XFER_VERIFY;
              end
              default: begin
                res.action = scc_pkg::ACT_WRITE;
                target.pending_transfer = scc_pkg::XFER_WRITE;
              end
            endcase
            res.start_sector = start;
            res.sectors = count;
          end
        end else begin
          case (r.opcode)
            scc_pkg::OP_TEST_UNIT_READY, scc_pkg::OP_SEND_DIAG, scc_pkg::OP_RESERVE,
            scc_pkg::OP_RELEASE: begin
              if (!target.medium_ready) begin
                refuse(res, scc_pkg::SK_NOT_READY, scc_pkg::AC_NO_MEDIUM);
              end else begin
                clear_sense();
              end
            end
            scc_pkg::OP_FORMAT_UNIT: clear_sense();
            scc_pkg::OP_READ_CAPACITY: begin
              clear_sense();
              res.action = scc_pkg::ACT_CAPACITY;
              res.last_sector = capacity - 32'd1;
            end
            scc_pkg::OP_REQUEST_SENSE: begin
              if (target.attention_pending) begin
                target.attention_pending = 1'b0;
                clear_sense();
              end
              res.action = scc_pkg::ACT_SENSE;
              res.data_length = b[4];
              res.sense_code = (lun != 3'd0) ? scc_pkg::SK_ILLEGAL : target.stored_sense;
              res.additional_code = (lun != 3'd0) ? scc_pkg::AC_BAD_LUN :
                                    target.stored_additional;
              clear_sense();
            end
            scc_pkg::OP_INQUIRY: begin
              if (target.attention_pending) begin
                target.attention_pending = 1'b0;
                clear_sense();
              end
              if (r.is_icd ? b[2][0] : b[1][0]) begin
                refuse(res, scc_pkg::SK_ILLEGAL, scc_pkg::AC_BAD_FIELD);
              end else begin
                clear_sense();
                res.action = scc_pkg::ACT_INQUIRY;
                res.data_length = r.is_icd ? b[5] : b[4];
              end
            end
            default: refuse(res, scc_pkg::SK_ILLEGAL, scc_pkg::AC_BAD_OPCODE);
          endcase
        end
      end
      default: ;
    endcase
    res.read_fail_count = target.read_failures;
    res.write_fail_count = target.write_failures;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  function automatic scc_pkg::req_t noise();
    scc_pkg::req_t r;
    r.mode = 2'($urandom_range(0, 3));
    r.opcode = 8'($urandom);
    r.is_icd = 1'($urandom_range(0, 1));
    r.cdb_front = $urandom;
    r.cdb_back[39:32] = 8'($urandom);
    r.cdb_back[31:0] = $urandom;
    r.transfer_failed = 1'($urandom_range(0, 1));
    r.pio_failed = 1'($urandom_range(0, 1));
    r.card_ready = 1'($urandom_range(0, 1));
    r.media_changed = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic scc_pkg::req_t cmd(input logic [7:0] op, input bit icd,
                                        input logic [71:0] cdb);
    scc_pkg::req_t r;
    r = noise();
    r.mode = scc_pkg::MODE_COMMAND;
    r.opcode = op;
    r.is_icd = icd;
    r.cdb_front = cdb[71:40];
    r.cdb_back = cdb[39:0];
    return r;
  endfunction

  function automatic scc_pkg::req_t done_req(input bit tf, input bit pf);
    scc_pkg::req_t r;
    r = noise();
    r.mode = scc_pkg::MODE_DONE;
    r.transfer_failed = tf;
    r.pio_failed = pf;
    return r;
  endfunction

  function automatic scc_pkg::req_t card_req(input bit rdy, input bit changed);
    scc_pkg::req_t r;
    r = noise();
    r.mode = scc_pkg::MODE_CARD;
    r.card_ready = rdy;
    r.media_changed = changed;
    return r;
  endfunction

  // mostly well-formed commands at lun 0, ranges often ending near the capacity boundary
  function automatic scc_pkg::req_t random_request(input logic [31:0] cap);
    logic [7:0]      ops [13];
    logic [1:9][7:0] b;
    scc_pkg::req_t   r;
    logic [31:0]     start;
    logic [15:0]     count;
    int              pick;
    ops = '{scc_pkg::OP_TEST_UNIT_READY, scc_pkg::OP_REQUEST_SENSE, scc_pkg::OP_FORMAT_UNIT,
            scc_pkg::OP_READ6, scc_pkg::OP_WRITE6, scc_pkg::OP_INQUIRY, scc_pkg::OP_RESERVE,
            scc_pkg::OP_RELEASE, scc_pkg::OP_SEND_DIAG, scc_pkg::OP_READ_CAPACITY,
            scc_pkg::OP_READ10, scc_pkg::OP_WRITE10, scc_pkg::OP_VERIFY};
    r = noise();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.mode = scc_pkg::MODE_CARD;
      r.card_ready = ($urandom_range(0, 5) != 0);
      r.media_changed = ($urandom_range(0, 3) == 0);
      return r;
    end
    if (pick < 20) begin
      r.mode = scc_pkg::MODE_DONE;
      return r;
    end
    if (pick < 23) begin
      r.mode = MODE_UNUSED;
      return r;
    end
    r.mode = scc_pkg::MODE_COMMAND;
    r.is_icd = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 6) != 0) r.opcode = ops[$urandom_range(0, 12)];
    b = {r.cdb_front, r.cdb_back};
    if (r.opcode inside {scc_pkg::OP_READ6, scc_pkg::OP_WRITE6} &&
        $urandom_range(0, 1) == 1) begin
      count = (b[4] == 8'd0) ? scc_pkg::SIX_BYTE_ZERO_COUNT : {8'd0, b[4]};
      start = cap - {16'd0, count} + $urandom_range(0, 4) - 32'd2;
      b[1][4:0] = start[20:16];
      b[2:3] = start[15:0];
    end
    if (r.opcode inside {scc_pkg::OP_READ10, scc_pkg::OP_WRITE10, scc_pkg::OP_VERIFY} &&
        $urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 7) == 0) b[8:9] = 16'd0;
      else if ($urandom_range(0, 1) == 1) b[8:9] = 16'($urandom_range(1, 300));
      count = b[8:9];
      start = cap - {16'd0, count} + $urandom_range(0, 4) - 32'd2;
      b[3:6] = start;
    end
    if ($urandom_range(0, 9) != 0) begin
      if (r.is_icd) b[2][7:5] = 3'd0;
      else b[1][7:5] = 3'd0;
    end
    if (r.opcode == scc_pkg::OP_INQUIRY && $urandom_range(0, 3) != 0) begin
      b[1][0] = 1'b0;
      b[2][0] = 1'b0;
    end
    r.cdb_front = b[1:4];
    r.cdb_back = b[5:9];
    return r;
  endfunction

  task automatic set_capacity(input logic [31:0] sectors);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= sectors;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // requests that give no status may still be in flight once the last status is in
  task automatic settle();
    while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin : driver
    if (!rst && (!in_valid || req_fire)) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        in_data <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 650)) begin
      holds_done++;
      hold_left = 59;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    scc_pkg::rsp_t want;
    scc_pkg::rsp_t next_status;
    bit            emits;
    req_fire <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected status, expected none actual %p", $time, out_data);
        end else begin
          want = status_due.pop_front();
          check_field("action", want.action, out_data.action);
          check_field("check_condition", want.check_condition, out_data.check_condition);
          check_field("sense_code", want.sense_code, out_data.sense_code);
          check_field("additional_code", want.additional_code, out_data.additional_code);
          check_field("start_sector", want.start_sector, out_data.start_sector);
          check_field("sectors", want.sectors, out_data.sectors);
          check_field("data_length", want.data_length, out_data.data_length);
          check_field("unit_number", want.unit_number, out_data.unit_number);
          check_field("last_sector", want.last_sector, out_data.last_sector);
          check_field("read_fail_count", want.read_fail_count, out_data.read_fail_count);
          check_field("write_fail_count", want.write_fail_count, out_data.write_fail_count);
        end
      end
      if (in_valid && in_ready) begin
        judge_request(in_data, emits, next_status);
        if (emits) status_due.push_back(next_status);
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
    end
  end

  initial begin : stimulus
    logic [31:0]   caps [8];
    scc_pkg::req_t r;
    int            p;
    int            k;
    caps = '{32'd0, 32'd1, 32'd256, 32'h001F_FFFF, 32'hFFFF_FFFF, $urandom, 32'd300,
             32'($urandom_range(0, 4000))};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_capacity(32'd1000);
    cmd_queue.push_back(cmd(scc_pkg::OP_TEST_UNIT_READY, 1'b0, 72'h0));
    cmd_queue.push_back(cmd(scc_pkg::OP_READ6, 1'b0, {8'h00, 8'h00, 8'h10, 8'h08, 40'h0}));
    cmd_queue.push_back(card_req(1'b1, 1'b1));
    cmd_queue.push_back(cmd(scc_pkg::OP_TEST_UNIT_READY, 1'b0, 72'h0));
    cmd_queue.push_back(cmd(scc_pkg::OP_REQUEST_SENSE, 1'b0, {24'h0, 8'h12, 40'h0}));
    // six-byte zero count means 256 sectors
    cmd_queue.push_back(cmd(scc_pkg::OP_READ6, 1'b0, {8'h1F, 8'hFF, 8'hFF, 8'h00, 40'h0}));
    cmd_queue.push_back(cmd(scc_pkg::OP_READ6, 1'b0, {8'h00, 8'h02, 8'hE8, 8'h00, 40'h0}));
    cmd_queue.push_back(done_req(1'b1, 1'b0));
    cmd_queue.push_back(cmd(scc_pkg::OP_WRITE10, 1'b0, {16'h0, 32'd999, 8'h00, 16'd1}));
    cmd_queue.push_back(done_req(1'b0, 1'b1));
    cmd_queue.push_back(cmd(scc_pkg::OP_VERIFY, 1'b0, {16'h0, 32'd1000, 8'h00, 16'd0}));
    cmd_queue.push_back(done_req(1'b1, 1'b1));
    cmd_queue.push_back(done_req(1'b0, 1'b0));
    cmd_queue.push_back(cmd(scc_pkg::OP_READ10, 1'b0,
                            {16'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF}));
    // pending write dropped by the next command
    cmd_queue.push_back(cmd(scc_pkg::OP_WRITE6, 1'b0, {8'h00, 8'h03, 8'hE7, 8'h01, 40'h0}));
    cmd_queue.push_back(cmd(scc_pkg::OP_READ_CAPACITY, 1'b0, 72'h0));
    cmd_queue.push_back(done_req(1'b1, 1'b0));
    cmd_queue.push_back(cmd(scc_pkg::OP_INQUIRY, 1'b1,
                            {8'h00, 8'h21, 8'h00, 8'h00, 8'h24, 32'h0}));
    cmd_queue.push_back(cmd(scc_pkg::OP_INQUIRY, 1'b1,
                            {8'hFF, 8'h00, 8'h00, 8'hFF, 8'h24, 32'h0}));
    cmd_queue.push_back(cmd(OP_UNDEFINED, 1'b0, 72'h0));
    cmd_queue.push_back(cmd(scc_pkg::OP_FORMAT_UNIT, 1'b0, {8'hE0, 64'h0}));
    cmd_queue.push_back(cmd(scc_pkg::OP_REQUEST_SENSE, 1'b0, {8'h60, 16'h0, 8'hFF, 40'h0}));
    cmd_queue.push_back(cmd(scc_pkg::OP_RESERVE, 1'b0, 72'h0));
    cmd_queue.push_back(cmd(scc_pkg::OP_RELEASE, 1'b0, 72'h0));
    cmd_queue.push_back(cmd(scc_pkg::OP_SEND_DIAG, 1'b0, 72'h0));
    r = noise();
    r.mode = MODE_UNUSED;
    cmd_queue.push_back(r);
    cmd_queue.push_back(card_req(1'b0, 1'b0));
    cmd_queue.push_back(cmd(scc_pkg::OP_VERIFY, 1'b0, {16'h0, 32'd0, 8'h00, 16'd1000}));
    cmd_queue.push_back(cmd(scc_pkg::OP_FORMAT_UNIT, 1'b0, 72'h0));
    settle();

    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      if (p == 7) calm = 1'b1;
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        r = random_request(caps[p]);
        cmd_queue.push_back(r);
        if (r.mode == scc_pkg::MODE_COMMAND &&
            r.opcode inside {scc_pkg::OP_READ6, scc_pkg::OP_WRITE6, scc_pkg::OP_READ10,
                             scc_pkg::OP_WRITE10, scc_pkg::OP_VERIFY} &&
            $urandom_range(0, 3) != 0)
          cmd_queue.push_back(done_req($urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0));
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
sv/scc_pkg.sv
sv/scc_decode.sv
sv/scsi_command_check_and_sense.sv
sim/testbench.sv
